/* design/smbwpec_pkg.sv */
// Shared types, constants and the PEC byte update for the SMBus read-word checker.
// No dependencies; used by every module of the block.

package smbwpec_pkg;

  localparam logic [7:0]  PEC_POLY        = 8'h07;
  localparam logic [6:0]  DEV_ADDR_RESET  = 7'd90;
  localparam logic [16:0] CENTI_K_OFFSET  = 17'd27315;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PEC_ERR = 2'd1;
  localparam logic [1:0] ST_SENSOR  = 2'd2;

  // Partial frame between the CRC stages and the result stage
  typedef struct packed {
    logic       valid;
    logic [7:0] crc;
    logic [7:0] data_low;
    logic [7:0] data_high;
    logic [7:0] pec_byte;
  } front_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] pec_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ PEC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/smbwpec_crc_pipe.sv */
// Two register stages of the PEC computation: address/command, then read address/low byte.
// Depends on smbwpec_pkg.

module smbwpec_crc_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_command,
  input  logic [7:0]            in_data_low,
  input  logic [7:0]            in_data_high,
  input  logic [7:0]            in_pec_byte,
  input  logic [6:0]            device_address,
  input  logic                  down_ready,
  output smbwpec_pkg::front_t   front
);

  smbwpec_pkg::front_t s1_r, s1_nxt, s2_r, s2_nxt;
  logic       s1_ld, s2_ld;
  logic [7:0] waddr, raddr;

  assign waddr = {device_address, 1'b0};
  assign raddr = {device_address, 1'b1};

  assign s2_ld    = !s2_r.valid || down_ready;
  assign s1_ld    = !s1_r.valid || s2_ld;
  assign in_stall = !s1_ld;

  always_comb begin
    s1_nxt           = s1_r;
    s1_nxt.valid     = in_valid;
    s1_nxt.crc       = smbwpec_pkg::pec_update(smbwpec_pkg::pec_update(8'h00, waddr),
                                               in_command);
    s1_nxt.data_low  = in_data_low;
    s1_nxt.data_high = in_data_high;
    s1_nxt.pec_byte  = in_pec_byte;
  end

  always_comb begin
    s2_nxt       = s1_r;
    s2_nxt.crc   = smbwpec_pkg::pec_update(smbwpec_pkg::pec_update(s1_r.crc, raddr),
                                           s1_r.data_low);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_r <= s1_nxt;
      end
      if (s2_ld) begin
        s2_r <= s2_nxt;
      end
    end
  end

  assign front = s2_r;

endmodule

/* design/smbwpec_result.sv */
// Last stage: high-byte CRC step, PEC compare, word assembly and Celsius conversion.
// Depends on smbwpec_pkg; holds the output register.

module smbwpec_result (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smbwpec_pkg::front_t   front,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [15:0]           out_raw_word,
  output logic signed [16:0]    out_temperature_centi_c
);

  logic              valid_r;
  logic [1:0]        status_r, status_nxt;
  logic [15:0]       raw_r, raw_nxt;
  logic [16:0]       temp_r, temp_nxt;
  logic [7:0]        crc;
  logic [15:0]       word;

  assign ready = !valid_r || !out_stall;
  assign crc   = smbwpec_pkg::pec_update(front.crc, front.data_high);
  assign word  = {front.data_high, front.data_low};

  always_comb begin
    status_nxt = smbwpec_pkg::ST_OK;
    raw_nxt    = word;
    temp_nxt   = {word, 1'b0} - smbwpec_pkg::CENTI_K_OFFSET;
    if (crc != front.pec_byte) begin
      status_nxt = smbwpec_pkg::ST_PEC_ERR;
      raw_nxt    = '0;
      temp_nxt   = '0;
    end else if (word[15]) begin
      status_nxt = smbwpec_pkg::ST_SENSOR;
      temp_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= front.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      status_r <= status_nxt;
      raw_r    <= raw_nxt;
      temp_r   <= temp_nxt;
    end
  end

  assign out_valid               = valid_r;
  assign out_status              = status_r;
  assign out_raw_word            = raw_r;
  assign out_temperature_centi_c = $signed(temp_r);

endmodule

/* design/smbus_word_pec_check_convert.sv */
// Top level of the SMBus read-word PEC checker and temperature converter.
// Depends on smbwpec_pkg, smbwpec_crc_pipe and smbwpec_result.
//
// Usage:
//   Input channel (in_valid / in_stall): one read-word response per transaction,
//   the command byte sent plus the low, high and PEC bytes received.
//   Output channel (out_valid / out_stall): one result per input transaction,
//   in order: status (0 ok, 1 PEC mismatch, 2 sensor error), the assembled
//   word and the temperature in hundredths of a degree Celsius.
//   Config channel (cfg_valid / cfg_ready): seven-bit device address used in
//   the PEC; cfg_ready is always high. Write it only while the block is empty.
//   One transaction per cycle is sustained while out_stall is low, set by the
//   three-stage CRC/compare pipeline.
//   Reset empties all stages and sets the device address to 90.
//   While the receiver stalls, the result holds and stages behind it keep
//   filling bubbles; in_stall rises only once every stage holds a transaction.

module smbus_word_pec_check_convert (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_command,
  input  logic [7:0]          in_data_low,
  input  logic [7:0]          in_data_high,
  input  logic [7:0]          in_pec_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [15:0]         out_raw_word,
  output logic signed [16:0]  out_temperature_centi_c,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_device_address
);

  logic [6:0]          dev_addr_r;
  logic                res_ready;
  smbwpec_pkg::front_t front;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= smbwpec_pkg::DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_device_address;
    end
  end

  smbwpec_crc_pipe u_crc (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_data_low    (in_data_low),
    .in_data_high   (in_data_high),
    .in_pec_byte    (in_pec_byte),
    .device_address (dev_addr_r),
    .down_ready     (res_ready),
    .front          (front)
  );

  smbwpec_result u_res (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .front                   (front),
    .ready                   (res_ready),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_raw_word            (out_raw_word),
    .out_temperature_centi_c (out_temperature_centi_c)
  );

  // Mismatch clears both result fields
  a_pec_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == smbwpec_pkg::ST_PEC_ERR |->
      out_raw_word == 16'd0 && out_temperature_centi_c == 17'sd0)
    else $error("PEC mismatch result not cleared");

  // Status must agree with the sensor error bit of the word
  a_sensor_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != smbwpec_pkg::ST_PEC_ERR |->
      (out_raw_word[15] == (out_status == smbwpec_pkg::ST_SENSOR)))
    else $error("status disagrees with sensor error bit");

  // With out_stall low, an accepted transaction passes both CRC stages and the result register to out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("transaction lost in pipeline");

endmodule

/* sim/smbus_word_pec_check_convert_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for smbus_word_pec_check_convert: directed and random
// read-word responses, with PEC, word and temperature predicted in the bench.
// Depends on smbwpec_pkg and the design sources only.

module smbus_word_pec_check_convert_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PIPE_LATENCY = 3;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        raw_word;
    logic signed [16:0] temperature;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_command;
  logic [7:0]         in_data_low;
  logic [7:0]         in_data_high;
  logic [7:0]         in_pec_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [15:0]        out_raw_word;
  logic signed [16:0] out_temperature_centi_c;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         cfg_device_address;

  logic [6:0] bus_address;
  reading_t   expected_readings[$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         tx_gaps_en = 1'b1;
  bit         rx_gaps_en = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  smbus_word_pec_check_convert i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_command              (in_command),
    .in_data_low             (in_data_low),
    .in_data_high            (in_data_high),
    .in_pec_byte             (in_pec_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_raw_word            (out_raw_word),
    .out_temperature_centi_c (out_temperature_centi_c),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_device_address      (cfg_device_address)
  );

  // CRC-8 over write address, command, read address, low and high byte, bit by bit
  function automatic logic [7:0] smbus_crc8(input logic [6:0] addr, input logic [7:0] cmd,
                                            input logic [7:0] lo, input logic [7:0] hi);
    logic [39:0] frame;
    logic [7:0]  crc;
    logic        feedback;
    frame = {addr, 1'b0, cmd, addr, 1'b1, lo, hi};
    crc = 8'h00;
    for (int i = 39; i >= 0; i--) begin
      feedback = crc[7] ^ frame[i];
      crc = {crc[6:0], 1'b0} ^ (feedback ? smbwpec_pkg::PEC_POLY : 8'h00);
    end
    return crc;
  endfunction

  function automatic reading_t predict_reading(input logic [6:0] addr, input logic [7:0] cmd,
                                               input logic [7:0] lo, input logic [7:0] hi,
                                               input logic [7:0] pec);
    reading_t    r;
    logic [15:0] word;
    int          centi;
    word = {hi, lo};
    r = '0;
    if (smbus_crc8(addr, cmd, lo, hi) != pec) begin
      r.status = smbwpec_pkg::ST_PEC_ERR;
    end else if (word[15]) begin
      r.status = smbwpec_pkg::ST_SENSOR;
      r.raw_word = word;
    end else begin
      r.status = smbwpec_pkg::ST_OK;
      r.raw_word = word;
      centi = int'(word) * 2 - int'(smbwpec_pkg::CENTI_K_OFFSET);
      r.temperature = centi[16:0];
    end
    return r;
  endfunction

  // Track the address register, queue predictions on acceptance, check results
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    cycle_count++;
    if (!rst_n) begin
      bus_address = smbwpec_pkg::DEV_ADDR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bus_address = cfg_device_address;
      end
      if (in_valid && !in_stall) begin
        expected_readings.push_back(predict_reading(bus_address, in_command, in_data_low,
                                                    in_data_high, in_pec_byte));
      end
      if (out_valid && !out_stall) begin
        got = '{out_status, out_raw_word, out_temperature_centi_c};
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected transaction, status %0d word %h temp %0d", $time,
                   got.status, got.raw_word, $signed(got.temperature));
          error_count++;
        end else begin
          want = expected_readings.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
            error_count++;
          end
          if (got.raw_word !== want.raw_word) begin
            $display("%0t: raw_word expected %h, actual %h", $time, want.raw_word,
                     got.raw_word);
            error_count++;
          end
          if (got.temperature !== want.temperature) begin
            $display("%0t: temperature expected %0d, actual %0d", $time,
                     $signed(want.temperature), $signed(got.temperature));
            error_count++;
          end
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts between runs of free flow
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_gaps_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_response(input logic [7:0] cmd, input logic [7:0] lo,
                               input logic [7:0] hi, input logic [7:0] pec);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_low <= lo;
    in_data_high <= hi;
    in_pec_byte <= pec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (tx_gaps_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_reading(input logic [7:0] cmd, input logic [7:0] lo, input logic [7:0] hi);
    send_response(cmd, lo, hi, smbus_crc8(bus_address, cmd, lo, hi));
  endtask

  task automatic send_random_response();
    logic [7:0] cmd;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] pec;
    cmd = 8'($urandom);
    lo = 8'($urandom);
    hi = 8'($urandom);
    // keep most words in temperature range
    if ($urandom_range(0, 3) != 0) hi[7] = 1'b0;
    pec = smbus_crc8(bus_address, cmd, lo, hi);
    if ($urandom_range(0, 4) == 0) begin
      pec = pec ^ 8'($urandom_range(1, 255));
    end
    send_response(cmd, lo, hi, pec);
  endtask

  // Hold the input until every transaction has come out and the pipe is empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_device_address(input logic [6:0] addr);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_device_address <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_frames();
    logic [7:0] good;
    send_reading(8'h07, 8'h00, 8'h00);
    send_reading(8'h07, 8'hFF, 8'h7F);
    send_reading(8'h06, 8'h00, 8'h80);
    send_reading(8'h00, 8'hFF, 8'hFF);
    send_reading(8'hFF, 8'h55, 8'h3A);
    send_reading(8'h00, 8'hAA, 8'h00);
    send_reading(8'hFF, 8'h00, 8'h7F);
    send_reading(8'h25, 8'h01, 8'h00);
    send_response(8'h07, 8'h00, 8'h00, 8'h00);
    send_response(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_response(8'h07, 8'h3C, 8'h12, 8'hFF);
    // single-bit PEC errors
    good = smbus_crc8(bus_address, 8'h07, 8'h3C, 8'h12);
    for (int b = 0; b < 8; b++) begin
      send_response(8'h07, 8'h3C, 8'h12, good ^ (8'h01 << b));
    end
  endtask

  task automatic test_address_extremes();
    logic [6:0] addrs[2];
    addrs = '{7'd0, 7'd127};
    foreach (addrs[k]) begin
      write_device_address(addrs[k]);
      send_reading(8'h07, 8'h00, 8'h00);
      send_reading(8'h07, 8'hFF, 8'h7F);
      send_reading(8'hFF, 8'h00, 8'h80);
      send_response(8'h07, 8'h10, 8'h3B, 8'h00);
      repeat (12) send_random_response();
    end
  endtask

  task automatic test_random_traffic();
    logic [6:0] addrs[4];
    addrs = '{7'($urandom), 7'h55, 7'h2A, smbwpec_pkg::DEV_ADDR_RESET};
    foreach (addrs[k]) begin
      write_device_address(addrs[k]);
      repeat (150) send_random_response();
      if (k == 1) drain_pipeline();
      repeat (150) send_random_response();
    end
  endtask

  task automatic test_streaming();
    tx_gaps_en = 1'b0;
    rx_gaps_en = 1'b0;
    repeat (100) send_random_response();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = 8'h00;
    in_data_low = 8'h00;
    in_data_high = 8'h00;
    in_pec_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_device_address = 7'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_address_extremes();
    test_random_traffic();
    test_streaming();
    drain_pipeline();
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
